FILE: design/pwmseq_pkg.sv
// ----------------------------------------------------------------------------
// pwmseq_pkg
// Shared types and codes for the packet word merger with sequence numbers.
// ----------------------------------------------------------------------------
`default_nettype none

package pwmseq_pkg;

  localparam int NUM_PORTS_DEF = 16;
  localparam int SEQ_BITS_DEF  = 16;

  localparam logic [7:0] WPM_RESET = 8'd128;

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_NONINIT = 2'd1;
  localparam logic [1:0] REQ_WORD    = 2'd2;
  localparam logic [1:0] REQ_EMPTY   = 2'd3;

  localparam logic [1:0] KIND_DESC   = 2'd0;
  localparam logic [1:0] KIND_PKT    = 2'd1;
  localparam logic [1:0] KIND_MERGED = 2'd2;

  localparam logic REG_WPM = 1'b0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  port;
    logic [2:0]  priority_req;
    logic [31:0] packet_id;
    logic [13:0] packet_size;
    logic        start_flag;
    logic        end_flag;
    logic        first_chunk;
    logic        last_chunk;
    logic [7:0]  valid_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  port;
    logic [2:0]  prio;
    logic [31:0] packet_id;
    logic [13:0] packet_size;
    logic        start_flag;
    logic        end_flag;
    logic        first_chunk;
    logic        last_chunk;
    logic [15:0] valid_bytes;
    logic [15:0] seq;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  typedef struct packed {
    logic             room;
    logic [CNT_W-1:0] level;
  } fifo_status_t;

endpackage

`default_nettype wire

FILE: design/pwmseq_merge.sv
// ----------------------------------------------------------------------------
// pwmseq_merge
// Grant decode, word accumulator and per-port sequence counters.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmseq_merge #(
  parameter int NUM_PORTS = pwmseq_pkg::NUM_PORTS_DEF,
  parameter int SEQ_BITS  = pwmseq_pkg::SEQ_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire pwmseq_pkg::item_t   item,
  input  wire logic [7:0]          wpm,
  output pwmseq_pkg::result_t      res0,
  output pwmseq_pkg::result_t      res1,
  output pwmseq_pkg::push_t        push
);

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [7:0]          merged_count;
  logic [31:0]         acc_packet_id;
  logic [3:0]          acc_port;
  logic [2:0]          acc_prio;
  logic [13:0]         acc_size;
  logic [3:0]          acc_flags;
  logic [15:0]         acc_vb;
  logic [SEQ_BITS-1:0] port_seq [NUM_PORTS];

  logic [7:0]          merged_count_next;
  logic [31:0]         acc_packet_id_next;
  logic [3:0]          acc_port_next;
  logic [2:0]          acc_prio_next;
  logic [13:0]         acc_size_next;
  logic [3:0]          acc_flags_next;
  logic [15:0]         acc_vb_next;

  logic                blocked;
  logic [7:0]          cnt_inc;
  logic [3:0]          in_flags;
  logic                emit;
  logic                in_range;
  logic [IDX_W-1:0]    src_idx;
  logic [SEQ_BITS-1:0] seq_base;
  logic [SEQ_BITS-1:0] seq_inc;
  logic [31:0]         seq_wide;
  pwmseq_pkg::push_t   push_raw;

  always_comb begin
    merged_count_next  = merged_count;
    acc_packet_id_next = acc_packet_id;
    acc_port_next      = acc_port;
    acc_prio_next      = acc_prio;
    acc_size_next      = acc_size;
    acc_flags_next     = acc_flags;
    acc_vb_next        = acc_vb;
    res0               = '0;
    res1               = '0;
    push_raw           = '0;
    emit               = 1'b0;

    blocked  = (merged_count == 8'hFF) || ((wpm != 8'd0) && (merged_count >= wpm));
    cnt_inc  = merged_count + 8'd1;
    in_flags = {item.last_chunk, item.first_chunk, item.end_flag, item.start_flag};

    unique case (item.req_type) inside
      pwmseq_pkg::REQ_INIT: begin
        res0.kind        = pwmseq_pkg::KIND_DESC;
        res0.port        = item.port;
        res0.prio        = item.priority_req;
        res1.kind        = pwmseq_pkg::KIND_PKT;
        res1.port        = item.port;
        res1.prio        = item.priority_req;
        res1.last_of_run = 1'b1;
        push_raw         = '{push0: 1'b1, push1: 1'b1};
        merged_count_next  = '0;
        acc_packet_id_next = '0;
        acc_port_next      = '0;
        acc_prio_next      = '0;
        acc_size_next      = '0;
        acc_flags_next     = '0;
        acc_vb_next        = '0;
      end
      pwmseq_pkg::REQ_NONINIT: begin
        res0.kind        = pwmseq_pkg::KIND_PKT;
        res0.port        = item.port;
        res0.prio        = item.priority_req;
        res0.last_of_run = 1'b1;
        push_raw         = '{push0: 1'b1, push1: 1'b0};
        merged_count_next  = '0;
        acc_packet_id_next = '0;
        acc_port_next      = '0;
        acc_prio_next      = '0;
        acc_size_next      = '0;
        acc_flags_next     = '0;
        acc_vb_next        = '0;
      end
      pwmseq_pkg::REQ_WORD, pwmseq_pkg::REQ_EMPTY: begin
        if (!blocked) begin
          merged_count_next = cnt_inc;
          if (item.req_type == pwmseq_pkg::REQ_WORD) begin
            if (cnt_inc == 8'd1) begin
              acc_packet_id_next = item.packet_id;
              acc_port_next      = item.port;
              acc_prio_next      = item.priority_req;
              acc_size_next      = item.packet_size;
              acc_flags_next     = in_flags;
              acc_vb_next        = 16'(item.valid_bytes);
            end else begin
              acc_flags_next = acc_flags | in_flags;
              acc_vb_next    = acc_vb + 16'(item.valid_bytes);
            end
          end
          emit = (wpm != 8'd0) && (cnt_inc == wpm);
        end
      end
      default: begin
      end
    endcase

    in_range = (32'(acc_port_next) < 32'(NUM_PORTS));
    src_idx  = IDX_W'(acc_port_next);
    if (!in_range || (acc_flags_next[0] && acc_flags_next[2])) begin
      seq_base = '0;
    end else begin
      seq_base = port_seq[src_idx];
    end
    seq_inc  = seq_base + SEQ_BITS'(1);
    seq_wide = 32'(seq_base);

    if (emit) begin
      res0.kind        = pwmseq_pkg::KIND_MERGED;
      res0.port        = acc_port_next;
      res0.prio        = acc_prio_next;
      res0.packet_id   = acc_packet_id_next;
      res0.packet_size = acc_size_next;
      res0.start_flag  = acc_flags_next[0];
      res0.end_flag    = acc_flags_next[1];
      res0.first_chunk = acc_flags_next[2];
      res0.last_chunk  = acc_flags_next[3];
      res0.valid_bytes = acc_vb_next;
      res0.seq         = seq_wide[15:0];
      res0.last_of_run = 1'b1;
    end
  end

  assign push.push0 = fire && (push_raw.push0 || emit);
  assign push.push1 = fire && push_raw.push1;

  always_ff @(posedge clk) begin
    if (rst) begin
      merged_count  <= '0;
      acc_packet_id <= '0;
      acc_port      <= '0;
      acc_prio      <= '0;
      acc_size      <= '0;
      acc_flags     <= '0;
      acc_vb        <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_seq[i] <= '0;
      end
    end else if (fire) begin
      merged_count  <= merged_count_next;
      acc_packet_id <= acc_packet_id_next;
      acc_port      <= acc_port_next;
      acc_prio      <= acc_prio_next;
      acc_size      <= acc_size_next;
      acc_flags     <= acc_flags_next;
      acc_vb        <= acc_vb_next;
      if (emit && in_range) begin
        port_seq[src_idx] <= seq_inc;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/pwmseq_out_fifo.sv
// ----------------------------------------------------------------------------
// pwmseq_out_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwmseq_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pwmseq_pkg::push_t    push,
  input  wire pwmseq_pkg::result_t  res0,
  input  wire pwmseq_pkg::result_t  res1,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output pwmseq_pkg::result_t       out_res,
  output pwmseq_pkg::fifo_status_t  status
);

  localparam int PTR_W = pwmseq_pkg::PTR_W;
  localparam int CNT_W = pwmseq_pkg::CNT_W;

  pwmseq_pkg::result_t entries [pwmseq_pkg::OUT_DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [CNT_W-1:0] level_next;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  always_comb begin
    pop         = out_valid && !out_stall;
    n_push      = CNT_W'(push.push0) + CNT_W'(push.push1);
    wr_ptr_next = wr_ptr + PTR_W'(n_push);
    level_next  = level + n_push - CNT_W'(pop);
  end

  assign out_valid    = (level != '0);
  assign out_res      = entries[rd_ptr];
  assign status.room  = (level <= CNT_W'(pwmseq_pkg::OUT_DEPTH - 2));
  assign status.level = level;

  always_ff @(posedge clk) begin
    if (push.push0) begin
      entries[wr_ptr] <= res0;
    end
    if (push.push1) begin
      entries[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/packet_word_merger_with_seq_top.sv
// ----------------------------------------------------------------------------
// packet_word_merger_with_seq_top
// Turns arbiter grants into FIFO requests and merges popped FIFO words into
// wide words tagged with a per-source-port sequence number.
//
//   channel   handshake            payload
//   input     in_valid/in_stall    req_type, port, priority_req, packet_id, ...
//   output    out_valid/out_stall  out_kind, out_port, ..., last_of_run
//   config    APB psel/penable     words_per_merge at byte address 0
//
// One item is taken per cycle while in_stall is low; it waits in the input
// register until it fires, then its results go into the four-entry queue.
// It waits while the queue has fewer than two free entries, so the output
// drain rate of one result per cycle, while out_stall is low, sets the rate
// for grants. Reset is synchronous and clears all counters at once.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_word_merger_with_seq_top #(
  parameter int NUM_PORTS = pwmseq_pkg::NUM_PORTS_DEF,
  parameter int SEQ_BITS  = pwmseq_pkg::SEQ_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  port,
  input  wire logic [2:0]  priority_req,
  input  wire logic [31:0] packet_id,
  input  wire logic [13:0] packet_size,
  input  wire logic        start_flag,
  input  wire logic        end_flag,
  input  wire logic        first_chunk,
  input  wire logic        last_chunk,
  input  wire logic [7:0]  valid_bytes,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_port,
  output logic [2:0]       out_priority,
  output logic [31:0]      out_packet_id,
  output logic [13:0]      out_packet_size,
  output logic             out_start,
  output logic             out_end,
  output logic             out_first_chunk,
  output logic             out_last_chunk,
  output logic [15:0]      out_valid_bytes,
  output logic [15:0]      sequence_number,
  output logic             last_of_run
);

  logic [7:0]                words_per_merge;
  logic                      in_q_valid;
  pwmseq_pkg::item_t         in_q;
  logic                      fire;
  logic                      take;
  pwmseq_pkg::result_t       res0;
  pwmseq_pkg::result_t       res1;
  pwmseq_pkg::push_t         push;
  pwmseq_pkg::result_t       out_res;
  pwmseq_pkg::fifo_status_t  fstat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pwmseq_pkg::REG_WPM) ? {24'd0, words_per_merge} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_merge <= pwmseq_pkg::WPM_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pwmseq_pkg::REG_WPM)) begin
      words_per_merge <= pwdata[7:0];
    end
  end

  assign fire     = in_q_valid && fstat.room;
  assign in_stall = in_q_valid && !fstat.room;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (take) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= '{req_type: req_type, port: port, priority_req: priority_req,
                packet_id: packet_id, packet_size: packet_size,
                start_flag: start_flag, end_flag: end_flag,
                first_chunk: first_chunk, last_chunk: last_chunk,
                valid_bytes: valid_bytes};
    end
  end

  pwmseq_merge #(
    .NUM_PORTS (NUM_PORTS),
    .SEQ_BITS  (SEQ_BITS)
  ) u_merge (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_q),
    .wpm  (words_per_merge),
    .res0 (res0),
    .res1 (res1),
    .push (push)
  );

  pwmseq_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .status    (fstat)
  );

  assign out_kind        = out_res.kind;
  assign out_port        = out_res.port;
  assign out_priority    = out_res.prio;
  assign out_packet_id   = out_res.packet_id;
  assign out_packet_size = out_res.packet_size;
  assign out_start       = out_res.start_flag;
  assign out_end         = out_res.end_flag;
  assign out_first_chunk = out_res.first_chunk;
  assign out_last_chunk  = out_res.last_chunk;
  assign out_valid_bytes = out_res.valid_bytes;
  assign sequence_number = out_res.seq;
  assign last_of_run     = out_res.last_of_run;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fstat.level) <= pwmseq_pkg::OUT_DEPTH)
    else $error("result queue overfilled");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("input stalled with an empty input register");

  a_grant_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && ((in_q.req_type == pwmseq_pkg::REQ_INIT) ||
             (in_q.req_type == pwmseq_pkg::REQ_NONINIT)) |=> out_valid)
    else $error("grant transfer produced no request");

  a_init_two_results: assert property (@(posedge clk) disable iff (rst)
    fire && (in_q.req_type == pwmseq_pkg::REQ_INIT) |-> push.push0 && push.push1)
    else $error("initial grant did not queue two requests");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for packet_word_merger_with_seq_top. Grants and popped
// words go in over the input channel and are mirrored in a bench-side merger
// model. Every output transfer is compared with the oldest predicted word.
// Directed tests cover the field extremes, grants, empty first pops, overrun
// pops, the 0 and 255 merge sizes and sequence numbering with restarts.
// Randomized packet bursts then run under three idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [2:0] WPM_ADDR = {pwmseq_pkg::REG_WPM, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [3:0]  port = '0;
  logic [2:0]  priority_req = '0;
  logic [31:0] packet_id = '0;
  logic [13:0] packet_size = '0;
  logic        start_flag = 1'b0;
  logic        end_flag = 1'b0;
  logic        first_chunk = 1'b0;
  logic        last_chunk = 1'b0;
  logic [7:0]  valid_bytes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [3:0]  out_port;
  logic [2:0]  out_priority;
  logic [31:0] out_packet_id;
  logic [13:0] out_packet_size;
  logic        out_start;
  logic        out_end;
  logic        out_first_chunk;
  logic        out_last_chunk;
  logic [15:0] out_valid_bytes;
  logic [15:0] sequence_number;
  logic        last_of_run;

  packet_word_merger_with_seq_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .port(port), .priority_req(priority_req), .packet_id(packet_id),
    .packet_size(packet_size), .start_flag(start_flag), .end_flag(end_flag),
    .first_chunk(first_chunk), .last_chunk(last_chunk),
    .valid_bytes(valid_bytes),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_port(out_port), .out_priority(out_priority),
    .out_packet_id(out_packet_id), .out_packet_size(out_packet_size),
    .out_start(out_start), .out_end(out_end),
    .out_first_chunk(out_first_chunk), .out_last_chunk(out_last_chunk),
    .out_valid_bytes(out_valid_bytes), .sequence_number(sequence_number),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // Bench copy of the merger state.
  logic [7:0]  wpm = pwmseq_pkg::WPM_RESET;
  logic [7:0]  pop_count = '0;
  logic [31:0] acc_id = '0;
  logic [3:0]  acc_port = '0;
  logic [2:0]  acc_prio = '0;
  logic [13:0] acc_size = '0;
  logic [3:0]  acc_flags = '0;
  logic [15:0] acc_bytes = '0;
  logic [15:0] port_seq [16] = '{default: '0};

  pwmseq_pkg::result_t mux_output_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_merged = 0;
  int n_seq_restarts = 0;
  int n_reg_writes = 0;
  int quiet_cycles = 0;

  function automatic pwmseq_pkg::item_t mk_item(logic [1:0] t, logic [3:0] p,
                                                logic [2:0] pr, logic [31:0] id,
                                                logic [13:0] sz, logic [3:0] fl,
                                                logic [7:0] vb);
    pwmseq_pkg::item_t it;
    it.req_type = t;
    it.port = p;
    it.priority_req = pr;
    it.packet_id = id;
    it.packet_size = sz;
    it.start_flag = fl[0];
    it.end_flag = fl[1];
    it.first_chunk = fl[2];
    it.last_chunk = fl[3];
    it.valid_bytes = vb;
    return it;
  endfunction

  function automatic pwmseq_pkg::item_t rand_item(logic [1:0] t, logic [3:0] p);
    return mk_item(t, p, 3'($urandom), $urandom, 14'($urandom), 4'($urandom),
                   8'($urandom));
  endfunction

  function automatic string fmt_result(pwmseq_pkg::result_t r);
    return $sformatf({"kind=%0d port=%0d pri=%0d id=%h size=%0d sefl=%b%b%b%b ",
                      "bytes=%0d seq=%0d last=%b"}, r.kind, r.port, r.prio,
                     r.packet_id, r.packet_size, r.start_flag, r.end_flag,
                     r.first_chunk, r.last_chunk, r.valid_bytes, r.seq,
                     r.last_of_run);
  endfunction

  function automatic void push_request(logic [1:0] k, logic [3:0] p,
                                       logic [2:0] pr, logic lst);
    pwmseq_pkg::result_t r;
    r = '0;
    r.kind = k;
    r.port = p;
    r.prio = pr;
    r.last_of_run = lst;
    mux_output_q.push_back(r);
  endfunction

  function automatic void step_merger(pwmseq_pkg::item_t it);
    pwmseq_pkg::result_t r;
    logic [3:0] fl;
    fl = {it.last_chunk, it.first_chunk, it.end_flag, it.start_flag};
    if (it.req_type == pwmseq_pkg::REQ_INIT || it.req_type == pwmseq_pkg::REQ_NONINIT) begin
      if (it.req_type == pwmseq_pkg::REQ_INIT) begin
        push_request(pwmseq_pkg::KIND_DESC, it.port, it.priority_req, 1'b0);
      end
      push_request(pwmseq_pkg::KIND_PKT, it.port, it.priority_req, 1'b1);
      pop_count = '0;
      acc_id = '0;
      acc_port = '0;
      acc_prio = '0;
      acc_size = '0;
      acc_flags = '0;
      acc_bytes = '0;
      return;
    end
    if (pop_count == 8'd255 || (wpm != 0 && pop_count >= wpm)) begin
      return;
    end
    pop_count++;
    if (it.req_type == pwmseq_pkg::REQ_WORD) begin
      if (pop_count == 8'd1) begin
        acc_id = it.packet_id;
        acc_port = it.port;
        acc_prio = it.priority_req;
        acc_size = it.packet_size;
        acc_flags = fl;
        acc_bytes = {8'd0, it.valid_bytes};
      end else begin
        acc_flags |= fl;
        acc_bytes += {8'd0, it.valid_bytes};
      end
    end
    if (wpm == 0 || pop_count != wpm) begin
      return;
    end
    if (acc_flags[0] && acc_flags[2]) begin
      port_seq[acc_port] = '0;
      n_seq_restarts++;
    end
    r.kind = pwmseq_pkg::KIND_MERGED;
    r.port = acc_port;
    r.prio = acc_prio;
    r.packet_id = acc_id;
    r.packet_size = acc_size;
    r.start_flag = acc_flags[0];
    r.end_flag = acc_flags[1];
    r.first_chunk = acc_flags[2];
    r.last_chunk = acc_flags[3];
    r.valid_bytes = acc_bytes;
    r.seq = port_seq[acc_port];
    r.last_of_run = 1'b1;
    port_seq[acc_port]++;
    n_merged++;
    mux_output_q.push_back(r);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  task automatic send_item(pwmseq_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req_type;
    port <= it.port;
    priority_req <= it.priority_req;
    packet_id <= it.packet_id;
    packet_size <= it.packet_size;
    start_flag <= it.start_flag;
    end_flag <= it.end_flag;
    first_chunk <= it.first_chunk;
    last_chunk <= it.last_chunk;
    valid_bytes <= it.valid_bytes;
    do @(posedge clk); while (in_stall);
    n_items++;
    step_merger(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (mux_output_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_check(logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= WPM_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) begin
      note_mismatch($sformatf("words_per_merge read %0d, wrote %0d", prdata[7:0], v));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_wpm(logic [7:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WPM_ADDR;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    wpm = v;
    n_reg_writes++;
    @(posedge clk);
    read_check(v);
  endtask

  task automatic test_pops_before_grant();
    read_check(pwmseq_pkg::WPM_RESET);
    send_item(rand_item(pwmseq_pkg::REQ_WORD, 4'd6));
    send_item(rand_item(pwmseq_pkg::REQ_EMPTY, 4'd6));
    send_item(rand_item(pwmseq_pkg::REQ_WORD, 4'd6));
    write_wpm(8'd2);
    send_item(rand_item(pwmseq_pkg::REQ_WORD, 4'd6));
  endtask

  task automatic test_grant_requests();
    send_item(mk_item(pwmseq_pkg::REQ_INIT, 4'd15, 3'd7, '1, '1, '1, '1));
    send_item(mk_item(pwmseq_pkg::REQ_NONINIT, 4'd0, 3'd0, '0, '0, '0, '0));
  endtask

  task automatic test_merge_fields();
    send_item(mk_item(pwmseq_pkg::REQ_INIT, 4'd3, 3'd1, '0, '0, '0, '0));
    send_item(mk_item(pwmseq_pkg::REQ_WORD, 4'd15, 3'd7, '1, '1, 4'b1111, 8'd255));
    send_item(mk_item(pwmseq_pkg::REQ_WORD, 4'd2, 3'd0, '0, '0, 4'b0000, 8'd255));
    send_item(mk_item(pwmseq_pkg::REQ_NONINIT, 4'd4, 3'd2, '0, '0, '0, '0));
    send_item(mk_item(pwmseq_pkg::REQ_EMPTY, 4'd9, 3'd5, 32'h1234_5678, 14'd99,
                      4'b1111, 8'd7));
    send_item(mk_item(pwmseq_pkg::REQ_WORD, 4'd5, 3'd3, 32'hdead_beef, 14'd77,
                      4'b0001, 8'd10));
    send_item(mk_item(pwmseq_pkg::REQ_NONINIT, 4'd0, 3'd0, '0, '0, '0, '0));
    send_item(mk_item(pwmseq_pkg::REQ_WORD, 4'd0, 3'd0, '0, '0, 4'b0000, 8'd0));
    send_item(mk_item(pwmseq_pkg::REQ_WORD, 4'd0, 3'd0, '0, '0, 4'b1010, 8'd0));
  endtask

  task automatic test_merge_overrun();
    send_item(rand_item(pwmseq_pkg::REQ_NONINIT, 4'd11));
    repeat (4) send_item(rand_item(pwmseq_pkg::REQ_WORD, 4'd11));
    send_item(rand_item(pwmseq_pkg::REQ_EMPTY, 4'd11));
  endtask

  task automatic test_size_extremes();
    write_wpm(8'd255);
    send_item(rand_item(pwmseq_pkg::REQ_NONINIT, 4'd12));
    repeat (255) send_item(mk_item(pwmseq_pkg::REQ_WORD, 4'd12, 3'($urandom), $urandom,
                                   14'($urandom), 4'($urandom), 8'd255));
    write_wpm(8'd0);
    send_item(rand_item(pwmseq_pkg::REQ_INIT, 4'd1));
    repeat (260) send_item(rand_item($urandom_range(3) == 0 ? pwmseq_pkg::REQ_EMPTY
                                                             : pwmseq_pkg::REQ_WORD, 4'd1));
    send_item(rand_item(pwmseq_pkg::REQ_NONINIT, 4'd1));
  endtask

  task automatic test_sequence_numbers();
    logic [3:0] p;
    write_wpm(8'd1);
    repeat (20) begin
      p = 4'($urandom_range(2, 4));
      send_item(rand_item(pwmseq_pkg::REQ_NONINIT, p));
      send_item(mk_item(pwmseq_pkg::REQ_WORD, p, 3'($urandom), $urandom,
                        14'($urandom), 4'($urandom), 8'($urandom)));
    end
  endtask

  task automatic run_bursts(int n);
    int start_count;
    int pops;
    logic [3:0] p;
    start_count = n_items;
    while (n_items - start_count < n) begin
      if ($urandom_range(9) == 0) begin
        send_item(rand_item(2'($urandom), 4'($urandom)));
      end else begin
        p = 4'($urandom);
        send_item(rand_item($urandom_range(1) ? pwmseq_pkg::REQ_INIT
                                              : pwmseq_pkg::REQ_NONINIT, p));
        pops = wpm;
        case ($urandom_range(9))
          0: pops = wpm + $urandom_range(1, 3);
          1: pops = $urandom_range(wpm);
          default: ;
        endcase
        repeat (pops) send_item(rand_item($urandom_range(7) == 0 ? pwmseq_pkg::REQ_EMPTY
                                                                 : pwmseq_pkg::REQ_WORD, p));
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 33 : 0;
      repeat (2) begin
        write_wpm(8'($urandom_range(1, 6)));
        run_bursts(78);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    pwmseq_pkg::result_t got;
    pwmseq_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {out_kind, out_port, out_priority, out_packet_id, out_packet_size,
             out_start, out_end, out_first_chunk, out_last_chunk, out_valid_bytes,
             sequence_number, last_of_run};
      n_results++;
      if (mux_output_q.size() == 0) begin
        note_mismatch({"unexpected transfer: ", fmt_result(got)});
      end else begin
        want = mux_output_q.pop_front();
        if (got !== want) begin
          note_mismatch({"got  ", fmt_result(got), "\n       want ", fmt_result(want)});
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, mux_output_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_pops_before_grant();
    test_grant_requests();
    test_merge_fields();
    test_merge_overrun();
    test_size_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_sequence_numbers();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d input transfers and %0d output transfers, %0d of them merged words",
             n_items, n_results, n_merged);
    $display("with %0d sequence restarts over %0d words_per_merge writes including 0 and 255.",
             n_seq_restarts, n_reg_writes);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pwmseq_pkg.sv
design/pwmseq_merge.sv
design/pwmseq_out_fifo.sv
design/packet_word_merger_with_seq_top.sv
tb/sv/tb_top.sv
